FILE: rtl/mrc_pkg.sv
package mrc_pkg;

    localparam int unsigned TERM_W  = 98;
    localparam int unsigned SUM_W   = 99;
    localparam int unsigned ACC_W   = 101;
    localparam int unsigned DEN_W   = 62;
    localparam int unsigned QUO_W   = 33;
    localparam int unsigned N_TERMS = 6;
    localparam int unsigned LATENCY = 40;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic              valid;
        logic              fallback;
        logic [31:0]       gzz;
        logic [DEN_W-1:0]  den;
    } side_t;

    typedef struct packed {
        side_t             side;
        logic              neg;
        logic              sat;
        logic [DEN_W-1:0]  rem;
        logic [QUO_W-1:0]  low;
        logic [QUO_W-1:0]  quo;
    } div_t;

endpackage

FILE: rtl/mrc_products.sv
module mrc_products
    import mrc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [30:0]               small_radius,
    input  logic signed [31:0]        pos_x,
    input  logic signed [31:0]        pos_y,
    input  logic signed [31:0]        pos_z,
    input  logic [30:0]               radius,
    input  logic signed [31:0]        g_xx,
    input  logic signed [31:0]        g_xy,
    input  logic signed [31:0]        g_xz,
    input  logic signed [31:0]        g_yy,
    input  logic signed [31:0]        g_yz,
    input  logic signed [31:0]        g_zz,
    output side_t                     side,
    output logic signed [TERM_W-1:0]  terms [N_TERMS]
);

    side_t                    side_a_reg, side_b_reg, side_c_reg;
    side_t                    side_a_next;
    logic signed [63:0]       p_reg [N_TERMS];
    logic signed [63:0]       p_next [N_TERMS];
    logic signed [31:0]       g_a_reg [N_TERMS];
    logic signed [31:0]       g_a_next [N_TERMS];
    logic signed [64:0]       lo_reg [N_TERMS];
    logic signed [64:0]       lo_next [N_TERMS];
    logic signed [63:0]       hi_reg [N_TERMS];
    logic signed [63:0]       hi_next [N_TERMS];
    logic signed [TERM_W-1:0] term_reg [N_TERMS];
    logic signed [TERM_W-1:0] term_next [N_TERMS];

    // coordinate products and radius squared
    always_comb
    begin
        side_a_next.valid    = in_valid;
        side_a_next.fallback = (radius <= small_radius) || (pos_x == 32'sd0 && pos_y == 32'sd0);
        side_a_next.gzz      = g_zz;
        side_a_next.den      = radius * radius;
        p_next[0] = pos_x * pos_x;
        p_next[1] = pos_y * pos_y;
        p_next[2] = pos_z * pos_z;
        p_next[3] = pos_x * pos_y;
        p_next[4] = pos_x * pos_z;
        p_next[5] = pos_y * pos_z;
        g_a_next[0] = g_xx;
        g_a_next[1] = g_yy;
        g_a_next[2] = g_zz;
        g_a_next[3] = g_xy;
        g_a_next[4] = g_xz;
        g_a_next[5] = g_yz;
    end

    // split 64 by 32 into two 32 by 32 partial products
    always_comb
    begin
        for (int i = 0; i < N_TERMS; i++)
        begin
            lo_next[i] = $signed({1'b0, p_reg[i][31:0]}) * g_a_reg[i];
            hi_next[i] = $signed(p_reg[i][63:32]) * g_a_reg[i];
        end
    end

    // recombine, cross terms doubled
    always_comb
    begin
        for (int i = 0; i < N_TERMS; i++)
        begin
            term_next[i] = $signed({{2{hi_reg[i][63]}}, hi_reg[i], 32'b0})
                         + $signed({{33{lo_reg[i][64]}}, lo_reg[i]});
            if (i >= 3)
            begin
                term_next[i] = term_next[i] <<< 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_a_reg <= '0;
            side_b_reg <= '0;
            side_c_reg <= '0;
        end
        else
        begin
            side_a_reg <= side_a_next;
            side_b_reg <= side_a_reg;
            side_c_reg <= side_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        g_a_reg  <= g_a_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        term_reg <= term_next;
    end

    assign side  = side_c_reg;
    assign terms = term_reg;

endmodule

FILE: rtl/mrc_accum.sv
module mrc_accum
    import mrc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  side_t                     side_in,
    input  logic signed [TERM_W-1:0]  terms [N_TERMS],
    output div_t                      div_out
);

    side_t                   side_d_reg, side_e_reg;
    logic signed [SUM_W-1:0] s_reg [3];
    logic signed [SUM_W-1:0] s_next [3];
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    div_t                    div_reg;
    div_t                    div_next;
    logic [ACC_W-1:0]        mag;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s_next[i] = SUM_W'(terms[2*i]) + SUM_W'(terms[2*i+1]);
        end
        acc_next = ACC_W'(s_reg[0]) + ACC_W'(s_reg[1]) + ACC_W'(s_reg[2]);
    end

    // magnitude and overflow check against the 33 bit quotient range
    always_comb
    begin
        mag              = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : acc_reg;
        div_next.side    = side_e_reg;
        div_next.neg     = acc_reg[ACC_W-1];
        div_next.sat     = mag >= {{(ACC_W-DEN_W-QUO_W){1'b0}}, side_e_reg.den, {QUO_W{1'b0}}};
        div_next.rem     = mag[DEN_W+QUO_W-1:QUO_W];
        div_next.low     = mag[QUO_W-1:0];
        div_next.quo     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_d_reg <= '0;
            side_e_reg <= '0;
            div_reg    <= '0;
        end
        else
        begin
            side_d_reg <= side_in;
            side_e_reg <= side_d_reg;
            div_reg    <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg   <= s_next;
        acc_reg <= acc_next;
    end

    assign div_out = div_reg;

endmodule

FILE: rtl/mrc_div_stage.sv
module mrc_div_stage
    import mrc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  div_t div_in,
    output div_t div_out
);

    div_t          div_reg;
    div_t          div_next;
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;

    // one restoring division step
    always_comb
    begin
        trial    = {div_in.rem, div_in.low[QUO_W-1]};
        diff     = trial - {1'b0, div_in.side.den};
        div_next = div_in;
        div_next.low = {div_in.low[QUO_W-2:0], 1'b0};
        if (trial >= {1'b0, div_in.side.den})
        begin
            div_next.rem = diff[DEN_W-1:0];
            div_next.quo = {div_in.quo[QUO_W-2:0], 1'b1};
        end
        else
        begin
            div_next.rem = trial[DEN_W-1:0];
            div_next.quo = {div_in.quo[QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg <= '0;
        end
        else
        begin
            div_reg <= div_next;
        end
    end

    assign div_out = div_reg;

endmodule

FILE: rtl/metric_radial_component.sv
// channel   | direction | transfer when          | payload
// ----------+-----------+------------------------+--------------------------------------
// input     | in        | start && !busy         | pos_x pos_y pos_z radius g_xx .. g_zz
// result    | out       | done (one cycle)       | g_rr on_axis
// config    | in        | cfg_valid && cfg_ready | cfg_data (small_radius)
//
// one point enters every cycle; busy is never raised
// a result passes through the six product and sum stages, the 33 stage divider
// and the rounding stage
// reset clears all valid bits and small_radius; no clearing pass
// the receiver cannot stall, so the pipeline advances every cycle
module metric_radial_component
    import mrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [30:0]        radius,
    input  logic signed [31:0] g_xx,
    input  logic signed [31:0] g_xy,
    input  logic signed [31:0] g_xz,
    input  logic signed [31:0] g_yy,
    input  logic signed [31:0] g_yz,
    input  logic signed [31:0] g_zz,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [30:0]        cfg_data,
    output logic               done,
    output logic signed [31:0] g_rr,
    output logic               on_axis
);

    logic [30:0]              small_radius_reg;
    side_t                    prod_side;
    logic signed [TERM_W-1:0] terms [N_TERMS];
    div_t                     div_chain [QUO_W+1];
    div_t                     fin;
    logic [QUO_W:0]           m;
    logic                     rnd_up;
    logic                     done_reg;
    logic                     done_next;
    logic [31:0]              g_rr_reg;
    logic [31:0]              g_rr_next;
    logic                     on_axis_reg;
    logic                     on_axis_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_radius_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            small_radius_reg <= cfg_data;
        end
    end

    mrc_products u_products (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start && !busy),
        .small_radius (small_radius_reg),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .radius       (radius),
        .g_xx         (g_xx),
        .g_xy         (g_xy),
        .g_xz         (g_xz),
        .g_yy         (g_yy),
        .g_yz         (g_yz),
        .g_zz         (g_zz),
        .side         (prod_side),
        .terms        (terms)
    );

    mrc_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .side_in (prod_side),
        .terms   (terms),
        .div_out (div_chain[0])
    );

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        mrc_div_stage u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .div_in  (div_chain[k]),
            .div_out (div_chain[k+1])
        );
    end

    assign fin = div_chain[QUO_W];

    // on-axis fallback passes g_zz; else round to nearest, ties away from zero, then saturate
    always_comb
    begin
        rnd_up       = {fin.rem, 1'b0} >= {1'b0, fin.side.den};
        m            = {1'b0, fin.quo} + (QUO_W+1)'(rnd_up);
        done_next    = fin.side.valid;
        on_axis_next = fin.side.fallback;
        if (fin.side.fallback)
        begin
            g_rr_next = fin.side.gzz;
        end
        else if (fin.sat)
        begin
            g_rr_next = fin.neg ? SAT_NEG : SAT_POS;
        end
        else if (fin.neg)
        begin
            if (m > (QUO_W+1)'(SAT_NEG))
                g_rr_next = SAT_NEG;
            else
                g_rr_next = 32'(-m);
        end
        else
        begin
            if (m > (QUO_W+1)'(SAT_POS))
                g_rr_next = SAT_POS;
            else
                g_rr_next = m[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_rr_reg    <= g_rr_next;
        on_axis_reg <= on_axis_next;
    end

    assign done    = done_reg;
    assign g_rr    = g_rr_reg;
    assign on_axis = on_axis_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("result missing after input transfer");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##LATENCY !done)
        else $error("result without input transfer");

    a_fallback_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && on_axis) |-> (g_rr == $past(g_zz, LATENCY)))
        else $error("fallback result differs from g_zz");

endmodule
